// ===== hdl/rolling_hash_chunk_boundary_unit_assert.svh =====
// ---------------------------------------------------------------------------
// rolling_hash_chunk_boundary_unit_assert.svh
// Assertion macros used by the checker of the chunk boundary unit.
// ---------------------------------------------------------------------------
`ifndef ROLLING_HASH_CHUNK_BOUNDARY_UNIT_ASSERT_SVH
`define ROLLING_HASH_CHUNK_BOUNDARY_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RHCB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RHCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rhcb_pkg.sv =====
// ---------------------------------------------------------------------------
// rhcb_pkg
// Types, constants and register codes of the chunk boundary unit.
// ---------------------------------------------------------------------------
package rhcb_pkg;

  localparam int RHCB_MAX_WINDOW = 64;
  localparam int RHCB_HASH_BITS  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REMOVE_COEFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHUNK_ID = 3'd7;

  // register reset values
  localparam logic [15:0] RST_HASH_BASE      = 16'd257;
  localparam logic [15:0] RST_REMOVE_COEFF   = 16'd0;
  localparam logic [6:0]  RST_WINDOW_SIZE    = 7'd48;
  localparam logic [15:0] RST_ANCHOR_MASK    = 16'd8191;
  localparam logic [15:0] RST_ANCHOR_VALUE   = 16'd0;
  localparam logic [15:0] RST_MIN_SIZE       = 16'd2048;
  localparam logic [15:0] RST_MAX_SIZE       = 16'd16384;
  localparam logic [31:0] RST_FIRST_CHUNK_ID = 32'd0;

  // cut reason codes
  localparam logic [1:0] CUT_NONE   = 2'd0;
  localparam logic [1:0] CUT_ANCHOR = 2'd1;
  localparam logic [1:0] CUT_MAX    = 2'd2;
  localparam logic [1:0] CUT_EOF    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        boundary;
    logic [1:0]  cut_reason;
    logic [15:0] chunk_length;
    logic [31:0] chunk_id;
    logic [15:0] hash_value;
  } out_word_t;

  // control from the sequencer to the hash step unit
  typedef struct packed {
    logic load;     // capture the outgoing-byte product
    logic filling;  // window not yet full: no outgoing byte
  } hstep_ctl_t;

endpackage

// ===== hdl/rhcb_window_ram.sv =====
// ---------------------------------------------------------------------------
// rhcb_window_ram
// Sliding window byte store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rhcb_window_ram #(
  parameter int DEPTH = rhcb_pkg::RHCB_MAX_WINDOW,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import rhcb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rhcb_hash_step.sv =====
// ---------------------------------------------------------------------------
// rhcb_hash_step
// Two-step hash update: outgoing-byte product, then (h - p) * base + byte.
// ---------------------------------------------------------------------------
module rhcb_hash_step #(
  parameter int HASH_BITS = rhcb_pkg::RHCB_HASH_BITS
) (
  input  logic                 clk,
  input  rhcb_pkg::hstep_ctl_t ctl,
  input  logic [7:0]           leave_byte,
  input  logic [HASH_BITS-1:0] coeff,
  input  logic [HASH_BITS-1:0] base,
  input  logic [HASH_BITS-1:0] hash,
  input  logic [7:0]           new_byte,
  output logic [HASH_BITS-1:0] hash_nxt
);
  import rhcb_pkg::*;

  localparam int HB = HASH_BITS;

  logic [HB+7:0]   leave_prod;
  logic [HB-1:0]   prod_r;
  logic [HB-1:0]   diff;
  logic [2*HB-1:0] mul_full;

  assign leave_prod = (HB + 8)'(leave_byte) * (HB + 8)'(coeff);

  // stage 1: outgoing term, zero while the window fills
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= ctl.filling ? '0 : leave_prod[HB-1:0];
    end
  end

  // stage 2: one multiply and add, modulo 2^HB
  assign diff     = hash - prod_r;
  assign mul_full = (2 * HB)'(diff) * (2 * HB)'(base);
  assign hash_nxt = mul_full[HB-1:0] + HB'(new_byte);

endmodule

// ===== hdl/rolling_hash_chunk_boundary_unit.sv =====
// ---------------------------------------------------------------------------
// rolling_hash_chunk_boundary_unit
// Content-defined chunking of a byte stream with a rolling polynomial hash.
// ---------------------------------------------------------------------------
// Each input word carries one file byte; each produces exactly one output
// word with the byte, the rolling hash after it, the chunk length and id,
// and a boundary flag with its reason (anchor match, max size, end of file).
// One byte is in flight at a time. The accepting edge also launches the
// window memory read of the outgoing byte; the MUL state then registers the
// outgoing-byte product, and the SUM state commits the multiply-add and cut
// check to the output register once the output register is free. The
// output register decouples the result side, so a new byte is taken on the
// edge after the previous one is committed, even while its result waits.
// The window lives in a MAX_WINDOW-entry byte memory; there is no clearing
// pass, since the byte count guarantees that no unwritten entry is ever
// used. Configuration is to be written only while the unit is idle; the
// unit itself does not enforce this. Writing first_chunk_id also reloads
// the chunk counter.
// ---------------------------------------------------------------------------
module rolling_hash_chunk_boundary_unit #(
  parameter int MAX_WINDOW = rhcb_pkg::RHCB_MAX_WINDOW,
  parameter int HASH_BITS  = rhcb_pkg::RHCB_HASH_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input byte channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rhcb_pkg::in_word_t                  in_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output rhcb_pkg::out_word_t                 out_word,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [rhcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhcb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rhcb_pkg::*;

  localparam int HB   = HASH_BITS;
  localparam int PTRW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW = PTRW + 1;
  localparam int WCW  = $clog2(MAX_WINDOW + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a byte
  localparam logic [1:0] ST_MUL  = 2'd1;  // outgoing byte read back, form product
  localparam logic [1:0] ST_SUM  = 2'd2;  // multiply-add, cut check, commit

  // configuration registers
  logic [15:0] hash_base_r;
  logic [15:0] remove_coeff_r;
  logic [6:0]  window_size_r;
  logic [15:0] anchor_mask_r;
  logic [15:0] anchor_value_r;
  logic [15:0] min_size_r;
  logic [15:0] max_size_r;

  // chunk state
  logic [1:0]      state_r, state_nxt;
  logic [PTRW-1:0] ptr_r, ptr_nxt;
  logic [HB-1:0]   hash_r;
  logic [15:0]     byte_cnt_r, byte_cnt_nxt;
  logic [31:0]     chunk_cnt_r;
  in_word_t        in_r;
  logic            out_valid_r;
  out_word_t       out_word_r, out_word_nxt;

  logic            in_acc;
  logic            out_free;
  logic            commit;
  logic [WCW-1:0]  win_eff;
  logic            filling;
  logic [SUMW-1:0] oidx_sum;
  logic [PTRW-1:0] oidx;
  logic [7:0]      leave_byte;
  logic [HB-1:0]   hash_new;
  logic [16:0]     len_inc;
  logic            anchor_hit;
  logic [1:0]      reason;
  hstep_ctl_t      hctl;

  // stall while a byte is in flight, and throughout reset
  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_SUM) && out_free;

  // effective window: zero acts as one, clamp at MAX_WINDOW
  always_comb begin
    if (window_size_r == 7'd0) begin
      win_eff = WCW'(1);
    end else if (16'(window_size_r) > 16'(MAX_WINDOW)) begin
      win_eff = WCW'(MAX_WINDOW);
    end else begin
      win_eff = WCW'(window_size_r);
    end
  end

  assign filling = byte_cnt_r < 16'(win_eff);

  // outgoing slot: (ptr - w) mod MAX_WINDOW, one compare and subtract
  assign oidx_sum = SUMW'(ptr_r) + SUMW'(MAX_WINDOW) - SUMW'(win_eff);
  assign oidx     = (oidx_sum >= SUMW'(MAX_WINDOW)) ?
                    PTRW'(oidx_sum - SUMW'(MAX_WINDOW)) : PTRW'(oidx_sum);

  rhcb_window_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (PTRW)
  ) u_window (
    .clk   (clk),
    .we    (commit),
    .waddr (ptr_r),
    .wdata (in_r.data_byte),
    .re    (in_acc),
    .raddr (oidx),
    .rdata (leave_byte)
  );

  assign hctl.load    = (state_r == ST_MUL);
  assign hctl.filling = filling;

  rhcb_hash_step #(
    .HASH_BITS (HB)
  ) u_hash (
    .clk        (clk),
    .ctl        (hctl),
    .leave_byte (leave_byte),
    .coeff      (remove_coeff_r[HB-1:0]),
    .base       (hash_base_r[HB-1:0]),
    .hash       (hash_r),
    .new_byte   (in_r.data_byte),
    .hash_nxt   (hash_new)
  );

  // cut decision; anchor beats max size beats end of file
  assign len_inc    = 17'(byte_cnt_r) + 17'd1;
  assign anchor_hit = ((16'(hash_new) & anchor_mask_r) == anchor_value_r);

  always_comb begin
    reason = CUT_NONE;
    if (!filling && (len_inc >= 17'(min_size_r))) begin
      if (anchor_hit) begin
        reason = CUT_ANCHOR;
      end else if (len_inc >= 17'(max_size_r)) begin
        reason = CUT_MAX;
      end
    end
    if ((reason == CUT_NONE) && in_r.last_byte) begin
      reason = CUT_EOF;
    end
  end

  // saturating length, pointer wrap
  always_comb begin
    byte_cnt_nxt = (byte_cnt_r == 16'hFFFF) ? byte_cnt_r : len_inc[15:0];
    ptr_nxt      = (ptr_r == PTRW'(MAX_WINDOW - 1)) ? '0 : ptr_r + PTRW'(1);
  end

  always_comb begin
    out_word_nxt.data_out     = in_r.data_byte;
    out_word_nxt.boundary     = (reason != CUT_NONE);
    out_word_nxt.cut_reason   = reason;
    out_word_nxt.chunk_length = byte_cnt_nxt;
    out_word_nxt.chunk_id     = chunk_cnt_r;
    out_word_nxt.hash_value   = 16'(hash_new);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    if (commit) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      ptr_r          <= '0;
      hash_r         <= '0;
      byte_cnt_r     <= '0;
      chunk_cnt_r    <= RST_FIRST_CHUNK_ID;
      out_valid_r    <= 1'b0;
      hash_base_r    <= RST_HASH_BASE;
      remove_coeff_r <= RST_REMOVE_COEFF;
      window_size_r  <= RST_WINDOW_SIZE;
      anchor_mask_r  <= RST_ANCHOR_MASK;
      anchor_value_r <= RST_ANCHOR_VALUE;
      min_size_r     <= RST_MIN_SIZE;
      max_size_r     <= RST_MAX_SIZE;
    end else begin
      state_r <= state_nxt;

      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (commit) begin
        if (reason != CUT_NONE) begin
          ptr_r       <= '0;
          hash_r      <= '0;
          byte_cnt_r  <= '0;
          chunk_cnt_r <= chunk_cnt_r + 32'd1;
        end else begin
          ptr_r      <= ptr_nxt;
          hash_r     <= hash_new;
          byte_cnt_r <= byte_cnt_nxt;
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_HASH_BASE:      hash_base_r    <= cfg_wdata[15:0];
          REG_REMOVE_COEFF:   remove_coeff_r <= cfg_wdata[15:0];
          REG_WINDOW_SIZE:    window_size_r  <= cfg_wdata[6:0];
          REG_ANCHOR_MASK:    anchor_mask_r  <= cfg_wdata[15:0];
          REG_ANCHOR_VALUE:   anchor_value_r <= cfg_wdata[15:0];
          REG_MIN_SIZE:       min_size_r     <= cfg_wdata[15:0];
          REG_MAX_SIZE:       max_size_r     <= cfg_wdata[15:0];
          REG_FIRST_CHUNK_ID: chunk_cnt_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/rhcb_checker.sv =====
// ---------------------------------------------------------------------------
// rhcb_checker
// Port-level checks of the chunk boundary unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "rolling_hash_chunk_boundary_unit_assert.svh"

module rhcb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rhcb_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input rhcb_pkg::out_word_t out_word
);
  import rhcb_pkg::*;

  // one byte in flight: an accepted word blocks the next edge
  `RHCB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "byte accepted while one in flight")

  // stalled input word stays offered and unchanged
  `RHCB_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_word), "stalled input changed")

  // held result stays put
  `RHCB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

  // boundary flag agrees with the reason code
  `RHCB_ASSERT_IMPLY(a_flag_reason, clk, rst_n, out_valid, out_word.boundary == (out_word.cut_reason != CUT_NONE), "boundary and cut_reason disagree")

  // every word counts itself in its chunk
  `RHCB_ASSERT_IMPLY(a_len_nonzero, clk, rst_n, out_valid, out_word.chunk_length != 16'd0, "zero chunk length")

endmodule

bind rolling_hash_chunk_boundary_unit rhcb_checker u_rhcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
